[rtl/core/stop_and_wait_connection_engine_assert.svh]
// Assertion macros used by the engine's RTL file.
// Define NO_ASSERTIONS to compile every use down to nothing.
`ifndef STOP_AND_WAIT_CONNECTION_ENGINE_ASSERT_SVH
`define STOP_AND_WAIT_CONNECTION_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is high.
`define SAWCE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in connection engine");

// Next-cycle implication, disabled while reset is high.
`define SAWCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in connection engine");

`else

`define SAWCE_ASSERT_NOW(label, clk, rst, ante, cons)
`define SAWCE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/core/sawce_pkg.sv]
`default_nettype none

package sawce_pkg;

   // Request and event codes.
   localparam logic [2:0] ACT_TICK    = 3'd0;
   localparam logic [2:0] ACT_CONNECT = 3'd1;
   localparam logic [2:0] ACT_LISTEN  = 3'd2;
   localparam logic [2:0] ACT_SEND    = 3'd3;
   localparam logic [2:0] ACT_RECEIVE = 3'd4;
   localparam logic [2:0] ACT_CLOSE   = 3'd5;

   // Connection phases, also reported on link_state.
   localparam logic [2:0] PH_CLOSED   = 3'd0;
   localparam logic [2:0] PH_LISTEN   = 3'd1;
   localparam logic [2:0] PH_SYNACK   = 3'd2;
   localparam logic [2:0] PH_SYNSENT  = 3'd3;
   localparam logic [2:0] PH_ESTAB    = 3'd4;
   localparam logic [2:0] PH_DATAWAIT = 3'd5;
   localparam logic [2:0] PH_FINWAIT  = 3'd6;
   localparam logic [2:0] PH_REMWAIT  = 3'd7;

   // Header flag encodings.
   localparam logic [5:0] FL_NONE   = 6'h00;
   localparam logic [5:0] FL_FIN    = 6'h01;
   localparam logic [5:0] FL_SYN    = 6'h02;
   localparam logic [5:0] FL_ACK    = 6'h10;
   localparam logic [5:0] FL_SYNACK = 6'h12;

   // Retransmit timeout after reset, in ticks.
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] initial_seq;
      logic [5:0] rx_flags;
      logic [7:0] rx_seq;
      logic [7:0] rx_ack;
      logic       rx_checksum_ok;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [5:0] tx_flags;
      logic [7:0] tx_seq;
      logic [7:0] tx_ack;
      logic       tx_window;
      logic [2:0] link_state;
      logic       op_done;
      logic       op_rejected;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/stop_and_wait_connection_engine.sv]
`default_nettype none
`include "stop_and_wait_connection_engine_assert.svh"

// Channel   Direction  Handshake           Beat
// req       in         req_valid/stall     one request or event (req_type)
// rsp       out        rsp_valid/stall     one result header and status (rsp_type)
// csr       in         csr_wr_en           retransmit timeout in ticks
//
// Every request beat produces exactly one response beat, registered in the cycle after acceptance.
// One request per clock is sustained unless rsp_stall holds a response; all decisions
// are made in a single pass between the request port and the response register.
// A stalled response holds the request side: req_stall follows rsp_stall while a
// response is waiting. Synchronous reset returns the link to closed and the
// timeout to 1000 ticks.
module stop_and_wait_connection_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire sawce_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sawce_pkg::rsp_type     rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [15:0]       csr_wr_data
);
   import sawce_pkg::*;

   logic [15:0] timeout_ff;
   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  local_seq_ff, local_seq_in;
   logic [7:0]  remote_seq_ff, remote_seq_in;
   logic [15:0] timer_ff, timer_in;
   logic        peer_closed_ff, peer_closed_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        req_accept;
   logic        rsp_take;
   logic [15:0] timeout_lim;
   logic [16:0] timer_next;
   logic        timer_fire;
   logic        waiting;
   logic [5:0]  pend_flags;
   logic [7:0]  pend_ack;

   // Handshake: a new beat may enter unless a finished response is stalled.
   assign rsp_take   = rsp_valid_ff & ~rsp_stall;
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Retransmit timer; a zero timeout behaves as one tick.
   assign timeout_lim = (timeout_ff == 16'd0) ? 16'd1 : timeout_ff;
   assign timer_next  = {1'b0, timer_ff} + 17'd1;
   assign timer_fire  = timer_next >= {1'b0, timeout_lim};
   assign waiting     = (phase_ff == PH_SYNACK) || (phase_ff == PH_SYNSENT) ||
                        (phase_ff == PH_DATAWAIT) || (phase_ff == PH_FINWAIT);

   // Header that is outstanding in the current phase.
   always_comb begin
      case (phase_ff)
         PH_SYNACK: begin
            pend_flags = FL_SYNACK;
            pend_ack   = remote_seq_ff;
         end
         PH_SYNSENT: begin
            pend_flags = FL_SYN;
            pend_ack   = 8'd0;
         end
         PH_FINWAIT: begin
            pend_flags = FL_FIN;
            pend_ack   = 8'd0;
         end
         default: begin
            pend_flags = FL_NONE;
            pend_ack   = 8'd0;
         end
      endcase
   end

   // Next connection state and response for the beat at the request port.
   always_comb begin
      phase_in       = phase_ff;
      local_seq_in   = local_seq_ff;
      remote_seq_in  = remote_seq_ff;
      timer_in       = timer_ff;
      peer_closed_in = peer_closed_ff;
      rsp_data_in    = '0;

      case (req_data.action)
         ACT_TICK: begin
            if (waiting) begin
               if (timer_fire) begin
                  timer_in              = 16'd0;
                  rsp_data_in.tx_valid  = 1'b1;
                  rsp_data_in.tx_flags  = pend_flags;
                  rsp_data_in.tx_seq    = local_seq_ff;
                  rsp_data_in.tx_ack    = pend_ack;
                  rsp_data_in.tx_window = 1'b1;
               end else begin
                  timer_in = timer_next[15:0];
               end
            end
         end
         ACT_CONNECT: begin
            if (phase_ff == PH_CLOSED || phase_ff == PH_LISTEN) begin
               local_seq_in          = req_data.initial_seq;
               phase_in              = PH_SYNSENT;
               timer_in              = 16'd0;
               rsp_data_in.tx_valid  = 1'b1;
               rsp_data_in.tx_flags  = FL_SYN;
               rsp_data_in.tx_seq    = req_data.initial_seq;
               rsp_data_in.tx_window = 1'b1;
            end else begin
               rsp_data_in.op_rejected = 1'b1;
            end
         end
         ACT_LISTEN: begin
            if (phase_ff == PH_CLOSED) begin
               local_seq_in = req_data.initial_seq;
               phase_in     = PH_LISTEN;
               timer_in     = 16'd0;
            end else begin
               rsp_data_in.op_rejected = 1'b1;
            end
         end
         ACT_SEND: begin
            if (phase_ff == PH_ESTAB) begin
               phase_in              = PH_DATAWAIT;
               timer_in              = 16'd0;
               rsp_data_in.tx_valid  = 1'b1;
               rsp_data_in.tx_flags  = FL_NONE;
               rsp_data_in.tx_seq    = local_seq_ff;
               rsp_data_in.tx_window = 1'b1;
            end else begin
               rsp_data_in.op_rejected = 1'b1;
            end
         end
         ACT_RECEIVE: begin
            case (phase_ff)
               PH_LISTEN: begin
                  if (req_data.rx_checksum_ok && req_data.rx_flags[1]) begin
                     remote_seq_in         = req_data.rx_seq;
                     phase_in              = PH_SYNACK;
                     timer_in              = 16'd0;
                     rsp_data_in.tx_valid  = 1'b1;
                     rsp_data_in.tx_flags  = FL_SYNACK;
                     rsp_data_in.tx_seq    = local_seq_ff;
                     rsp_data_in.tx_ack    = req_data.rx_seq;
                     rsp_data_in.tx_window = 1'b1;
                  end
               end
               PH_SYNACK, PH_DATAWAIT: begin
                  if (req_data.rx_checksum_ok && req_data.rx_flags[4] &&
                      req_data.rx_ack == local_seq_ff) begin
                     local_seq_in        = local_seq_ff + 8'd1;
                     phase_in            = PH_ESTAB;
                     timer_in            = 16'd0;
                     rsp_data_in.op_done = 1'b1;
                  end
               end
               PH_SYNSENT: begin
                  if (req_data.rx_checksum_ok && req_data.rx_flags[4] &&
                      req_data.rx_flags[1] && req_data.rx_ack == local_seq_ff) begin
                     remote_seq_in         = req_data.rx_seq;
                     phase_in              = PH_ESTAB;
                     timer_in              = 16'd0;
                     rsp_data_in.tx_valid  = 1'b1;
                     rsp_data_in.tx_flags  = FL_ACK;
                     rsp_data_in.tx_ack    = req_data.rx_seq;
                     rsp_data_in.tx_window = 1'b1;
                     rsp_data_in.op_done   = 1'b1;
                  end
               end
               PH_FINWAIT: begin
                  if (req_data.rx_checksum_ok) begin
                     if (!req_data.rx_flags[4]) begin
                        // The peer closes first: acknowledge its FIN.
                        if (req_data.rx_flags[0]) begin
                           rsp_data_in.tx_valid = 1'b1;
                           rsp_data_in.tx_flags = FL_ACK;
                           rsp_data_in.tx_ack   = req_data.rx_seq;
                           peer_closed_in       = 1'b1;
                        end
                     end else if (req_data.rx_ack == local_seq_ff) begin
                        if (peer_closed_ff) begin
                           phase_in            = PH_CLOSED;
                           local_seq_in        = 8'd0;
                           remote_seq_in       = 8'd0;
                           timer_in            = 16'd0;
                           peer_closed_in      = 1'b0;
                           rsp_data_in.op_done = 1'b1;
                        end else begin
                           phase_in = PH_REMWAIT;
                           timer_in = 16'd0;
                        end
                     end
                  end
               end
               PH_REMWAIT: begin
                  // Any packet from the peer is acknowledged and the link closes.
                  rsp_data_in.tx_valid = 1'b1;
                  rsp_data_in.tx_flags = FL_ACK;
                  rsp_data_in.tx_ack   = req_data.rx_seq;
                  phase_in             = PH_CLOSED;
                  local_seq_in         = 8'd0;
                  remote_seq_in        = 8'd0;
                  timer_in             = 16'd0;
                  peer_closed_in       = 1'b0;
                  rsp_data_in.op_done  = 1'b1;
               end
               default: begin
               end
            endcase
         end
         ACT_CLOSE: begin
            if (phase_ff == PH_ESTAB) begin
               phase_in              = PH_FINWAIT;
               timer_in              = 16'd0;
               peer_closed_in        = 1'b0;
               rsp_data_in.tx_valid  = 1'b1;
               rsp_data_in.tx_flags  = FL_FIN;
               rsp_data_in.tx_seq    = local_seq_ff;
               rsp_data_in.tx_window = 1'b1;
            end else if (phase_ff <= PH_SYNSENT) begin
               phase_in            = PH_CLOSED;
               local_seq_in        = 8'd0;
               remote_seq_in       = 8'd0;
               timer_in            = 16'd0;
               peer_closed_in      = 1'b0;
               rsp_data_in.op_done = 1'b1;
            end else begin
               rsp_data_in.op_rejected = 1'b1;
            end
         end
         default: begin
         end
      endcase

      rsp_data_in.link_state = phase_in;
   end

   // Timeout register.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   // Connection state, updated once per accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_CLOSED;
         local_seq_ff   <= 8'd0;
         remote_seq_ff  <= 8'd0;
         timer_ff       <= 16'd0;
         peer_closed_ff <= 1'b0;
      end else if (req_accept) begin
         phase_ff       <= phase_in;
         local_seq_ff   <= local_seq_in;
         remote_seq_ff  <= remote_seq_in;
         timer_ff       <= timer_in;
         peer_closed_ff <= peer_closed_in;
      end
   end

   // Response register: filled on accept, emptied when the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // A closed link holds every counter at its reset value.
   `SAWCE_ASSERT_NOW(a_closed_clean, clock, reset, phase_ff == PH_CLOSED,
      local_seq_ff == 8'd0 && remote_seq_ff == 8'd0 && timer_ff == 16'd0 && !peer_closed_ff)
   // Header fields are zero when no header is sent.
   `SAWCE_ASSERT_NOW(a_idle_header_zero, clock, reset, rsp_valid_ff && !rsp_data_ff.tx_valid,
      rsp_data_ff.tx_flags == FL_NONE && rsp_data_ff.tx_seq == 8'd0 &&
      rsp_data_ff.tx_ack == 8'd0 && !rsp_data_ff.tx_window)
   // A request cannot both complete and be refused.
   `SAWCE_ASSERT_NOW(a_status_exclusive, clock, reset, rsp_valid_ff,
      !(rsp_data_ff.op_done && rsp_data_ff.op_rejected))
   // Every accepted beat leaves a response that reports the new phase.
   `SAWCE_ASSERT_NEXT(a_accept_reports, clock, reset, req_accept,
      rsp_valid_ff && rsp_data_ff.link_state == phase_ff)

endmodule

`default_nettype wire

[tb/link_checker.sv]
module link_checker
   import sawce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int          outstanding,
   output int          mismatches,
   output int          beats_checked,
   output int          resends,
   output int          close_acks
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the engine's state and its timeout register.
   logic [15:0] timeout_ticks;
   logic [2:0]  phase;
   logic [7:0]  local_seq;
   logic [7:0]  remote_seq;
   logic [15:0] retry_timer;
   logic        peer_fin_seen;

   // Results predicted for accepted request beats, oldest first.
   rsp_type due_results[$];

   // One line per bad beat, with the printing capped to keep the log short.
   task automatic report_mismatch(string what, rsp_type got, rsp_type want);
      mismatches++;
      if (mismatches <= 40) begin
         $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
      end
   endtask

   // Put a header on the result beat.
   function automatic rsp_type with_header(rsp_type r, logic [5:0] flags, logic [7:0] seq,
                                           logic [7:0] ack, logic win);
      r.tx_valid  = 1'b1;
      r.tx_flags  = flags;
      r.tx_seq    = seq;
      r.tx_ack    = ack;
      r.tx_window = win;
      return r;
   endfunction

   // The header that the current phase is still waiting to have answered.
   function automatic rsp_type resend_header(rsp_type r);
      case (phase)
         PH_SYNACK:   r = with_header(r, FL_SYNACK, local_seq, remote_seq, 1'b1);
         PH_SYNSENT:  r = with_header(r, FL_SYN, local_seq, 8'd0, 1'b1);
         PH_DATAWAIT: r = with_header(r, FL_NONE, local_seq, 8'd0, 1'b1);
         PH_FINWAIT:  r = with_header(r, FL_FIN, local_seq, 8'd0, 1'b1);
         default: ;
      endcase
      return r;
   endfunction

   // Back to the state right after reset; the timeout register is kept.
   function automatic void clear_link();
      phase         = PH_CLOSED;
      local_seq     = 8'd0;
      remote_seq    = 8'd0;
      retry_timer   = 16'd0;
      peer_fin_seen = 1'b0;
   endfunction

   // Work out the result of one request beat and advance the shadow state.
   function automatic rsp_type next_link_result(req_type q);
      rsp_type     r;
      logic [16:0] limit;
      logic [16:0] count;
      logic        acked;
      r = '0;
      acked = q.rx_checksum_ok && ((q.rx_flags & FL_ACK) == FL_ACK) &&
              (q.rx_ack == local_seq);
      case (q.action)
         ACT_TICK: begin
            // Only phases that wait for an answer run the retransmit timer.
            if (phase == PH_SYNACK || phase == PH_SYNSENT ||
                phase == PH_DATAWAIT || phase == PH_FINWAIT) begin
               limit = (timeout_ticks == 16'd0) ? 17'd1 : {1'b0, timeout_ticks};
               count = {1'b0, retry_timer} + 17'd1;
               if (count >= limit) begin
                  r = resend_header(r);
                  retry_timer = 16'd0;
               end else begin
                  retry_timer = count[15:0];
               end
            end
         end
         ACT_CONNECT: begin
            if (phase == PH_CLOSED || phase == PH_LISTEN) begin
               local_seq   = q.initial_seq;
               phase       = PH_SYNSENT;
               retry_timer = 16'd0;
               r = resend_header(r);
            end else begin
               r.op_rejected = 1'b1;
            end
         end
         ACT_LISTEN: begin
            if (phase == PH_CLOSED) begin
               local_seq   = q.initial_seq;
               phase       = PH_LISTEN;
               retry_timer = 16'd0;
            end else begin
               r.op_rejected = 1'b1;
            end
         end
         ACT_SEND: begin
            if (phase == PH_ESTAB) begin
               phase       = PH_DATAWAIT;
               retry_timer = 16'd0;
               r = resend_header(r);
            end else begin
               r.op_rejected = 1'b1;
            end
         end
         ACT_RECEIVE: begin
            case (phase)
               PH_LISTEN: begin
                  if (q.rx_checksum_ok && (q.rx_flags & FL_SYN) == FL_SYN) begin
                     remote_seq  = q.rx_seq;
                     phase       = PH_SYNACK;
                     retry_timer = 16'd0;
                     r = resend_header(r);
                  end
               end
               PH_SYNACK, PH_DATAWAIT: begin
                  if (acked) begin
                     local_seq   = local_seq + 8'd1;
                     phase       = PH_ESTAB;
                     retry_timer = 16'd0;
                     r.op_done   = 1'b1;
                  end
               end
               PH_SYNSENT: begin
                  if (q.rx_checksum_ok && (q.rx_flags & FL_SYNACK) == FL_SYNACK &&
                      q.rx_ack == local_seq) begin
                     remote_seq  = q.rx_seq;
                     phase       = PH_ESTAB;
                     retry_timer = 16'd0;
                     r = with_header(r, FL_ACK, 8'd0, remote_seq, 1'b1);
                     r.op_done = 1'b1;
                  end
               end
               PH_FINWAIT: begin
                  // A FIN from the peer without ACK gets a close ack at once.
                  if (q.rx_checksum_ok && (q.rx_flags & FL_ACK) != FL_ACK) begin
                     if ((q.rx_flags & FL_FIN) == FL_FIN) begin
                        r = with_header(r, FL_ACK, 8'd0, q.rx_seq, 1'b0);
                        peer_fin_seen = 1'b1;
                     end
                  end else if (acked) begin
                     if (peer_fin_seen) begin
                        clear_link();
                        r.op_done = 1'b1;
                     end else begin
                        phase       = PH_REMWAIT;
                        retry_timer = 16'd0;
                     end
                  end
               end
               PH_REMWAIT: begin
                  // Any packet at all, good checksum or not, closes the link.
                  r = with_header(r, FL_ACK, 8'd0, q.rx_seq, 1'b0);
                  clear_link();
                  r.op_done = 1'b1;
               end
               default: ;
            endcase
         end
         ACT_CLOSE: begin
            if (phase == PH_ESTAB) begin
               phase         = PH_FINWAIT;
               retry_timer   = 16'd0;
               peer_fin_seen = 1'b0;
               r = resend_header(r);
            end else if (phase <= PH_SYNSENT) begin
               clear_link();
               r.op_done = 1'b1;
            end else begin
               r.op_rejected = 1'b1;
            end
         end
         default: ;
      endcase
      r.link_state = phase;
      return r;
   endfunction

   // Field by field comparison of one result beat.
   task automatic compare_result(rsp_type got, rsp_type want);
      string fields;
      fields = "";
      if (got.tx_valid !== want.tx_valid) fields = {fields, " tx_valid"};
      if (got.tx_flags !== want.tx_flags) fields = {fields, " tx_flags"};
      if (got.tx_seq !== want.tx_seq) fields = {fields, " tx_seq"};
      if (got.tx_ack !== want.tx_ack) fields = {fields, " tx_ack"};
      if (got.tx_window !== want.tx_window) fields = {fields, " tx_window"};
      if (got.link_state !== want.link_state) fields = {fields, " link_state"};
      if (got.op_done !== want.op_done) fields = {fields, " op_done"};
      if (got.op_rejected !== want.op_rejected) fields = {fields, " op_rejected"};
      beats_checked++;
      if (fields != "") begin
         report_mismatch({"wrong field(s):", fields}, got, want);
      end
   endtask

   // Watch both channels and the register port at every clock edge.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         timeout_ticks = TIMEOUT_RESET;
         clear_link();
         due_results.delete();
      end else begin
         if (csr_wr_en) timeout_ticks = csr_wr_data;
         if (req_valid && !req_stall) begin
            want = next_link_result(req_data);
            due_results.push_back(want);
            if (req_data.action == ACT_TICK && want.tx_valid) resends++;
            if (want.tx_valid && !want.tx_window) close_acks++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               report_mismatch("result beat with no request outstanding", rsp_data, '0);
            end else begin
               want = due_results.pop_front();
               compare_result(rsp_data, want);
            end
         end
      end
      outstanding <= due_results.size();
   end

endmodule

[tb/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sawce_pkg::*;

   // Action codes the engine does not define; they must have no effect.
   localparam logic [2:0] ACT_SPARE_LO = 3'd6;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;
   localparam int PHASE_BEATS = 160;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = 16'd0;

   int outstanding;
   int mismatches;
   int beats_checked;
   int resends;
   int close_acks;

   // Where the stimulus believes the link is, so that sequences stay well formed.
   logic [2:0]  plan_phase   = PH_CLOSED;
   logic [7:0]  plan_seq     = 8'd0;
   logic [15:0] plan_timeout = TIMEOUT_RESET;
   int          burst_left   = 0;
   int          beats_sent   = 0;
   int          sessions     = 0;
   int          settings_used = 0;
   int          phase_start;
   logic [15:0] timeout_plan [7];

   stop_and_wait_connection_engine dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   link_checker link_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .outstanding   (outstanding),
      .mismatches    (mismatches),
      .beats_checked (beats_checked),
      .resends       (resends),
      .close_acks    (close_acks)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the run in case the engine stops answering.
   initial begin
      #5_000_000;
      $display("Timed out with %0d result beats still outstanding.", outstanding);
      $display("FAIL");
      $finish;
   end

   // Receiver stall pattern: free stretches, light and heavy random stalls, long holds.
   initial begin
      int span;
      forever begin
         span = $urandom_range(10, 80);
         case ($urandom_range(0, 3))
            0: repeat (span) @(posedge clock) rsp_stall <= 1'b0;
            1: repeat (span) @(posedge clock) rsp_stall <= ($urandom_range(0, 2) == 0);
            2: repeat (span) @(posedge clock) rsp_stall <= ($urandom_range(0, 3) != 0);
            default: begin
               repeat ($urandom_range(5, 25)) @(posedge clock) rsp_stall <= 1'b1;
               @(posedge clock) rsp_stall <= 1'b0;
            end
         endcase
      end
   end

   // A request beat with every field random apart from the action.
   function automatic req_type random_beat(logic [2:0] act);
      logic [63:0] noise_bits;
      req_type     b;
      noise_bits = {$urandom, $urandom};
      b = noise_bits[$bits(req_type)-1:0];
      b.action = act;
      return b;
   endfunction

   function automatic req_type coded_beat(logic [2:0] act, logic [7:0] seq);
      req_type b;
      b = random_beat(act);
      b.initial_seq = seq;
      return b;
   endfunction

   function automatic req_type packet_beat(logic [5:0] flags, logic [7:0] seq,
                                           logic [7:0] ack, logic ok);
      req_type b;
      b = random_beat(ACT_RECEIVE);
      b.rx_flags       = flags;
      b.rx_seq         = seq;
      b.rx_ack         = ack;
      b.rx_checksum_ok = ok;
      return b;
   endfunction

   // A beat that leaves the planned phase alone: ticks, spare codes, packets the
   // phase does not wait for, and requests the phase forbids.
   function automatic req_type stray_beat();
      req_type    b;
      logic [7:0] wrong_ack;
      wrong_ack = plan_seq ^ 8'($urandom_range(1, 255));
      b = random_beat(ACT_TICK);
      case ($urandom_range(0, 3))
         0: ;
         1: b = random_beat($urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO);
         2: begin
            if (plan_phase != PH_REMWAIT) begin
               b = random_beat(ACT_RECEIVE);
               if ($urandom_range(0, 2) == 0) begin
                  b.rx_checksum_ok = 1'b0;
               end else begin
                  b.rx_checksum_ok = 1'b1;
                  case (plan_phase)
                     PH_LISTEN: b.rx_flags = b.rx_flags & ~FL_SYN;
                     PH_SYNACK, PH_SYNSENT, PH_DATAWAIT: b.rx_ack = wrong_ack;
                     PH_FINWAIT: begin
                        if ($urandom_range(0, 1)) begin
                           b.rx_flags = b.rx_flags | FL_ACK;
                           b.rx_ack   = wrong_ack;
                        end else begin
                           b.rx_flags = b.rx_flags & ~(FL_ACK | FL_FIN);
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         default: begin
            case (plan_phase)
               PH_CLOSED: b = random_beat($urandom_range(0, 1) ? ACT_SEND : ACT_CLOSE);
               PH_LISTEN, PH_SYNACK, PH_SYNSENT:
                  b = random_beat($urandom_range(0, 1) ? ACT_SEND : ACT_LISTEN);
               PH_ESTAB: b = random_beat($urandom_range(0, 1) ? ACT_CONNECT : ACT_LISTEN);
               default: begin
                  case ($urandom_range(0, 3))
                     0: b = random_beat(ACT_CONNECT);
                     1: b = random_beat(ACT_LISTEN);
                     2: b = random_beat(ACT_SEND);
                     default: b = random_beat(ACT_CLOSE);
                  endcase
               end
            endcase
         end
      endcase
      return b;
   endfunction

   // Offer one beat and hold it until accepted; the sender idles between bursts.
   task automatic push_beat(req_type b);
      int gap;
      if (burst_left <= 0) begin
         if ($urandom_range(0, 9) == 0) begin
            gap = 0;
            burst_left = $urandom_range(40, 120);
         end else begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 10);
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (req_stall);
      burst_left--;
      beats_sent++;
   endtask

   // Stop sending and wait until every predicted result has come back.
   task automatic hold_for_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_timeout(logic [15:0] ticks);
      hold_for_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ticks;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      plan_timeout = ticks;
      settings_used++;
   endtask

   // Ticks mixed with stray beats, enough to force retransmits at short timeouts.
   task automatic wait_events();
      int n;
      n = $urandom_range(0, (plan_timeout <= 16'd8) ? 3 * plan_timeout + 3 : 6);
      repeat (n) begin
         if ($urandom_range(0, 9) < 7) push_beat(random_beat(ACT_TICK));
         else push_beat(stray_beat());
      end
   endtask

   task automatic open_with(logic [2:0] act);
      req_type b;
      b = random_beat(act);
      plan_seq = b.initial_seq;
      push_beat(b);
   endtask

   task automatic abort_link();
      push_beat(random_beat(ACT_CLOSE));
      plan_phase = PH_CLOSED;
   endtask

   // One connection from open to close, with random content and stray beats.
   task automatic run_session();
      logic fin_from_peer;
      sessions++;
      if ($urandom_range(0, 1)) begin
         // Active open, sometimes out of the listen phase.
         if ($urandom_range(0, 3) == 0) begin
            open_with(ACT_LISTEN);
            plan_phase = PH_LISTEN;
            wait_events();
         end
         open_with(ACT_CONNECT);
         plan_phase = PH_SYNSENT;
         wait_events();
         if ($urandom_range(0, 7) == 0) begin
            abort_link();
            return;
         end
         push_beat(packet_beat(6'($urandom) | FL_SYNACK, 8'($urandom), plan_seq, 1'b1));
         plan_phase = PH_ESTAB;
      end else begin
         // Passive open: wait for SYN, answer, then take the ACK.
         open_with(ACT_LISTEN);
         plan_phase = PH_LISTEN;
         wait_events();
         if ($urandom_range(0, 7) == 0) begin
            abort_link();
            return;
         end
         push_beat(packet_beat(6'($urandom) | FL_SYN, 8'($urandom), 8'($urandom), 1'b1));
         plan_phase = PH_SYNACK;
         wait_events();
         if ($urandom_range(0, 7) == 0) begin
            abort_link();
            return;
         end
         push_beat(packet_beat(6'($urandom) | FL_ACK, 8'($urandom), plan_seq, 1'b1));
         plan_seq = plan_seq + 8'd1;
         plan_phase = PH_ESTAB;
      end

      // Stop-and-wait data transfer.
      wait_events();
      repeat ($urandom_range(0, 4)) begin
         push_beat(random_beat(ACT_SEND));
         plan_phase = PH_DATAWAIT;
         wait_events();
         push_beat(packet_beat(6'($urandom) | FL_ACK, 8'($urandom), plan_seq, 1'b1));
         plan_seq = plan_seq + 8'd1;
         plan_phase = PH_ESTAB;
      end

      // Close, with the peer's FIN arriving before or after our FIN is acked.
      push_beat(random_beat(ACT_CLOSE));
      plan_phase = PH_FINWAIT;
      wait_events();
      fin_from_peer = 1'b0;
      repeat ($urandom_range(0, 2)) begin
         push_beat(packet_beat((6'($urandom) & ~FL_ACK) | FL_FIN, 8'($urandom),
                               8'($urandom), 1'b1));
         fin_from_peer = 1'b1;
         wait_events();
      end
      push_beat(packet_beat(6'($urandom) | FL_ACK, 8'($urandom), plan_seq, 1'b1));
      if (!fin_from_peer) begin
         plan_phase = PH_REMWAIT;
         wait_events();
         push_beat(random_beat(ACT_RECEIVE));
      end
      plan_phase = PH_CLOSED;
   endtask

   // Main stimulus and verdict.
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats at the reset timeout: extremes, rejections and both closes.
      push_beat(coded_beat(ACT_SEND, 8'h00));
      push_beat(coded_beat(ACT_CLOSE, 8'hFF));
      push_beat(coded_beat(ACT_SPARE_LO, 8'hFF));
      push_beat(coded_beat(ACT_SPARE_HI, 8'h00));
      push_beat(packet_beat(6'h3F, 8'hFF, 8'hFF, 1'b1));
      push_beat(coded_beat(ACT_LISTEN, 8'hFF));
      push_beat(packet_beat(6'h3D, 8'h00, 8'hFF, 1'b1));
      push_beat(packet_beat(FL_SYN, 8'h55, 8'h00, 1'b0));
      push_beat(coded_beat(ACT_CONNECT, 8'h00));
      push_beat(coded_beat(ACT_TICK, 8'h00));
      push_beat(packet_beat(FL_SYNACK, 8'hFF, 8'h01, 1'b1));
      push_beat(packet_beat(FL_SYNACK, 8'hFF, 8'h00, 1'b1));
      push_beat(coded_beat(ACT_LISTEN, 8'h12));
      push_beat(coded_beat(ACT_CONNECT, 8'h34));
      push_beat(coded_beat(ACT_SEND, 8'h00));
      push_beat(packet_beat(FL_ACK, 8'h00, 8'h00, 1'b1));
      push_beat(coded_beat(ACT_CLOSE, 8'h00));
      push_beat(coded_beat(ACT_SEND, 8'h00));
      push_beat(coded_beat(ACT_CLOSE, 8'h00));
      push_beat(packet_beat(FL_FIN, 8'hAA, 8'h00, 1'b1));
      push_beat(packet_beat(FL_ACK | FL_FIN, 8'h00, 8'h01, 1'b1));
      push_beat(coded_beat(ACT_LISTEN, 8'h80));
      push_beat(packet_beat(6'h3F, 8'h00, 8'h00, 1'b1));
      push_beat(coded_beat(ACT_CLOSE, 8'h00));
      push_beat(coded_beat(ACT_CONNECT, 8'hFF));
      push_beat(coded_beat(ACT_CLOSE, 8'h00));
      plan_phase = PH_CLOSED;

      // Random sessions under a series of timeout settings, extremes included.
      timeout_plan = '{16'd1, 16'd0, 16'd3, 16'd65535, 16'd2,
                       16'($urandom_range(4, 12)), 16'd5};
      foreach (timeout_plan[i]) begin
         write_timeout(timeout_plan[i]);
         phase_start = beats_sent;
         while (beats_sent - phase_start < PHASE_BEATS) run_session();
      end

      hold_for_idle();
      repeat (5) @(posedge clock);
      $display("Sent %0d request beats in %0d sessions over %0d timeout settings.",
               beats_sent, sessions, settings_used + 1);
      $display("Checked %0d result beats, including %0d retransmits and %0d close acks.",
               beats_checked, resends, close_acks);
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
